### hw/rtl/utf8_stream_decoder_macros.svh
// Assertion macros used by the UTF-8 stream decoder core
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
// check a property on every clock edge outside reset
`define UTF8SD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("utf8sd assertion failed");
// check a property on every clock edge, reset included
`define UTF8SD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("utf8sd assertion failed");
`else
`define UTF8SD_ASSERT(label, prop)
`define UTF8SD_ASSERT_ALWAYS(label, prop)
`endif

`endif

### hw/rtl/utf8sd_pkg.sv
// Package: types, constants and lead-byte decode for the UTF-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 31;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned CONT_W    = 6;
    localparam int unsigned ASCII_W   = 7;
    localparam int unsigned TDATA_W   = ((CP_W + LEN_W + 7) / 8) * 8;

    // lead byte thresholds
    localparam logic [BYTE_W-1:0] LEAD_2B = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_5B = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_6B = 8'hFC;

    // payload masks kept from the lead byte
    localparam logic [BYTE_W-1:0] MASK_2B = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_3B = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_4B = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_5B = 8'h03;
    localparam logic [BYTE_W-1:0] MASK_6B = 8'h01;
    localparam logic [BYTE_W-1:0] MASK_CONT = 8'h3F;

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

    // one decoded result
    typedef struct packed {
        logic                vld;
        logic [CP_W-1:0]     code_point;
        logic [LEN_W-1:0]    seq_len;
    } t_result;

    // lead byte classification
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [ASCII_W-1:0]  val;
    } t_lead;

    function automatic t_lead classify_lead(input logic [BYTE_W-1:0] b);
        t_lead       r;
        logic [BYTE_W-1:0] m;
        m = '0;
        if (b < LEAD_2B) begin
            r.len = LEN_1;
            m     = b;
        end else if (b < LEAD_3B) begin
            r.len = LEN_2;
            m     = b & MASK_2B;
        end else if (b < LEAD_4B) begin
            r.len = LEN_3;
            m     = b & MASK_3B;
        end else if (b < LEAD_5B) begin
            r.len = LEN_4;
            m     = b & MASK_4B;
        end else if (b < LEAD_6B) begin
            r.len = LEN_5;
            m     = b & MASK_5B;
        end else begin
            r.len = LEN_6;
            m     = b & MASK_6B;
        end
        r.val = m[ASCII_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8sd_core.sv
// Decode core: sequence state registers and the per-byte update logic
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8sd_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [utf8sd_pkg::BYTE_W-1:0] i_byte,
    output utf8sd_pkg::t_result                o_res
);
    import utf8sd_pkg::*;

    logic [CP_W-1:0]  r_accum,      n_accum;
    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [LEN_W-1:0] r_cur_len,    n_cur_len;
    t_lead            lead;
    logic [CP_W-1:0]  shifted;
    logic [LEN_W-1:0] left_dec;

    assign lead     = classify_lead(i_byte);
    assign shifted  = {r_accum[CP_W-CONT_W-1:0], i_byte[CONT_W-1:0]};
    assign left_dec = r_bytes_left - LEN_1;

    // next state and result for the byte in hand
    always_comb begin
        n_accum      = r_accum;
        n_bytes_left = r_bytes_left;
        n_cur_len    = r_cur_len;
        o_res        = '0;
        if (i_vld) begin
            if (r_bytes_left == '0) begin
                if (lead.len == LEN_1) begin
                    // single byte: emit at once, stay idle
                    o_res.vld        = 1'b1;
                    o_res.code_point = CP_W'(lead.val);
                    o_res.seq_len    = LEN_1;
                    n_accum          = '0;
                    n_cur_len        = '0;
                end else begin
                    n_accum      = CP_W'(lead.val);
                    n_cur_len    = lead.len;
                    n_bytes_left = lead.len - LEN_1;
                end
            end else begin
                // continuation, taken without checking its top bits
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    o_res.vld        = 1'b1;
                    o_res.code_point = shifted;
                    o_res.seq_len    = r_cur_len;
                    n_accum          = '0;
                    n_cur_len        = '0;
                end else begin
                    n_accum = shifted;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= '0;
            r_bytes_left <= '0;
            r_cur_len    <= '0;
        end else begin
            r_accum      <= n_accum;
            r_bytes_left <= n_bytes_left;
            r_cur_len    <= n_cur_len;
        end
    end

    `UTF8SD_ASSERT(a_left_range, r_bytes_left <= LEN_5)
    `UTF8SD_ASSERT(a_idle_clear, (r_bytes_left == '0) |-> (r_cur_len == '0 && r_accum == '0))
    `UTF8SD_ASSERT(a_open_len, (r_bytes_left != '0) |-> (r_cur_len > r_bytes_left))
    `UTF8SD_ASSERT(a_res_len, o_res.vld |-> (o_res.seq_len != '0 && o_res.seq_len != 3'd7))

endmodule

`default_nettype wire

### hw/rtl/utf8sd_out.sv
// Output register holding one decoded result until the sink takes it
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_out (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire utf8sd_pkg::t_result            i_res,
    input  wire logic                           i_tready,
    output logic                                o_tvalid,
    output logic [utf8sd_pkg::TDATA_W-1:0]      o_tdata
);
    import utf8sd_pkg::*;

    logic             r_vld;
    logic [CP_W-1:0]  r_cp;
    logic [LEN_W-1:0] r_len;

    // valid flag: set on a new result, dropped once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load && i_res.vld) begin
            r_vld <= 1'b1;
        end else if (i_tready) begin
            r_vld <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.vld) begin
            r_cp  <= i_res.code_point;
            r_len <= i_res.seq_len;
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = {(TDATA_W - CP_W - LEN_W)'(0), r_len, r_cp};

endmodule

`default_nettype wire

### hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder (six-byte form): top level with input register and flow control
//
// Takes one UTF-8 byte per request on the slave side and returns one code
// point with its sequence length when a sequence completes; bytes 0x80-0xBF
// seen as a lead open a two-byte sequence and continuation bytes are not
// checked. Throughput is one byte per cycle while results are accepted: the
// state update is a single shift-and-merge into the 31-bit accumulator. The
// byte that completes a sequence passes through the input register, then its
// result is captured in the result register and shown on the master side.
// While a result waits unaccepted the decoder holds one further byte in its
// input register and then stalls.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [utf8sd_pkg::BYTE_W-1:0] i_s_axis_tdata,  // [7:0] in_byte
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [utf8sd_pkg::TDATA_W-1:0]     o_m_axis_tdata   // [30:0] code_point,
                                                                // [33:31] seq_len, rest 0
);
    import utf8sd_pkg::*;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              advance;
    t_result           res;

    // byte in the input register moves on when the result slot is free
    assign advance         = r_in_vld && (!o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    utf8sd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    utf8sd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_res    (res),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### tb/tb_utf8_stream_decoder.sv
// Self-checking stream testbench for the six-byte UTF-8 stream decoder
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

    import utf8sd_pkg::*;

    // one decoded character as the decoder should return it
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_len;
    } t_decoded;

    // tracks the open sequence and holds the characters still to come out
    class utf8_scoreboard;
        logic [CP_W-1:0]  accum;
        logic [LEN_W-1:0] bytes_left;
        logic [LEN_W-1:0] cur_len;
        t_decoded         chars_due[$];
        int               errors;

        function new();
            accum      = '0;
            bytes_left = '0;
            cur_len    = '0;
            errors     = 0;
        endfunction

        // accepted byte: advance the decode state, queue a character when one completes
        function void note_byte(logic [BYTE_W-1:0] b);
            t_decoded d;
            if (bytes_left == '0) begin
                if (b < LEAD_2B) begin
                    d.code_point = CP_W'(b);
                    d.seq_len    = LEN_1;
                    chars_due.push_back(d);
                    accum   = '0;
                    cur_len = '0;
                end else begin
                    // stray continuation bytes fall in with the two-byte leads
                    if (b < LEAD_3B) begin
                        cur_len = LEN_2;
                        accum   = CP_W'(b & MASK_2B);
                    end else if (b < LEAD_4B) begin
                        cur_len = LEN_3;
                        accum   = CP_W'(b & MASK_3B);
                    end else if (b < LEAD_5B) begin
                        cur_len = LEN_4;
                        accum   = CP_W'(b & MASK_4B);
                    end else if (b < LEAD_6B) begin
                        cur_len = LEN_5;
                        accum   = CP_W'(b & MASK_5B);
                    end else begin
                        cur_len = LEN_6;
                        accum   = CP_W'(b & MASK_6B);
                    end
                    bytes_left = cur_len - LEN_1;
                end
            end else begin
                // continuation is never checked, only its low six bits count
                accum      = {accum[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    d.code_point = accum;
                    d.seq_len    = cur_len;
                    chars_due.push_back(d);
                    accum   = '0;
                    cur_len = '0;
                end
            end
        endfunction

        // accepted result: compare against the oldest character due
        function void check_result(logic [TDATA_W-1:0] tdata);
            t_decoded d;
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got cp=%h len=%0d", $time,
                         tdata[CP_W-1:0], tdata[CP_W+LEN_W-1:CP_W]);
                errors++;
                return;
            end
            d = chars_due.pop_front();
            if (tdata[CP_W-1:0] !== d.code_point) begin
                $display("%0t: code_point mismatch, expected %h, got %h", $time,
                         d.code_point, tdata[CP_W-1:0]);
                errors++;
            end
            if (tdata[CP_W+LEN_W-1:CP_W] !== d.seq_len) begin
                $display("%0t: seq_len mismatch, expected %0d, got %0d", $time,
                         d.seq_len, tdata[CP_W+LEN_W-1:CP_W]);
                errors++;
            end
            if (tdata[TDATA_W-1:CP_W+LEN_W] !== '0) begin
                $display("%0t: tdata padding mismatch, expected 0, got %h", $time,
                         tdata[TDATA_W-1:CP_W+LEN_W]);
                errors++;
            end
        endfunction

        function int pending();
            return chars_due.size();
        endfunction
    endclass

    localparam int TOTAL_BYTES = 1650;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;    // [7:0] in_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [30:0] code_point, [33:31] seq_len, rest 0

    utf8_scoreboard board;
    int             src_idle_pct;
    int             snk_stall_pct;
    int             bytes_sent;

    utf8_stream_decoder DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_utf8_stream_decoder failed");
        $finish;
    end

    // one byte request, with random idle cycles before it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= BYTE_W'($urandom_range(255));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_byte(b);
        bytes_sent++;
    endtask

    // mostly well-formed sequences; some truncated ones and some stray bytes
    task automatic send_random_sequence();
        int          len;
        int          n_cont;
        logic [7:0]  lead;
        if ($urandom_range(99) < 8) begin
            send_byte(BYTE_W'($urandom_range(255)));
            return;
        end
        len = $urandom_range(1, 6);
        case (len)
            1:       lead = BYTE_W'($urandom_range(8'h00, 8'h7F));
            2:       lead = BYTE_W'($urandom_range(8'h80, 8'hDF));
            3:       lead = BYTE_W'($urandom_range(8'hE0, 8'hEF));
            4:       lead = BYTE_W'($urandom_range(8'hF0, 8'hF7));
            5:       lead = BYTE_W'($urandom_range(8'hF8, 8'hFB));
            default: lead = BYTE_W'($urandom_range(8'hFC, 8'hFF));
        endcase
        n_cont = len - 1;
        if (n_cont > 0 && $urandom_range(99) < 6)
            n_cont = $urandom_range(0, n_cont - 1);
        send_byte(lead);
        repeat (n_cont) begin
            if ($urandom_range(99) < 90)
                send_byte({2'b10, 6'($urandom_range(63))});
            else
                send_byte(BYTE_W'($urandom_range(255)));
        end
    endtask

    // receiver: random stalls, check every accepted result
    initial begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // main sequence
    initial begin
        logic [BYTE_W-1:0] directed[$];
        board         = new();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        bytes_sent    = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII extremes, stray continuation as lead, ASCII and lead bytes
        // in continuation position, five-byte form, full 31-bit six-byte form
        directed = '{8'h00, 8'h7F,
                     8'h80, 8'hBF,
                     8'hE0, 8'hFF, 8'h41,
                     8'hF7, 8'hBF, 8'hC0, 8'h3F,
                     8'hFB, 8'h80, 8'h80, 8'h80, 8'h80,
                     8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        src_idle_pct  = 30;
        snk_stall_pct = 73;
        foreach (directed[i]) send_byte(directed[i]);

        while (bytes_sent < TOTAL_BYTES / 3) send_random_sequence();
        src_idle_pct  = 73;
        snk_stall_pct = 30;
        while (bytes_sent < 2 * TOTAL_BYTES / 3) send_random_sequence();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        while (bytes_sent < TOTAL_BYTES) send_random_sequence();
        s_tvalid <= 1'b0;

        // drain outstanding characters, then allow for pipeline latency
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("tb_utf8_stream_decoder passed");
        else
            $display("tb_utf8_stream_decoder failed");
        $finish;
    end

endmodule

### utf8_stream_decoder.f
+incdir+hw/rtl
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_core.sv
hw/rtl/utf8sd_out.sv
hw/rtl/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
